>>> hdl/apt_pkg.sv
// Package: shared types and codes of the airfoil polar table interpolator.
`default_nettype none

package apt_pkg;

    localparam int unsigned VAL_W  = 32;
    localparam int unsigned CMD_W  = 2;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned CFG_IW = 1;

    // Commands
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_ORDER = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_EXT_LO = 1'd0;
    localparam logic [CFG_IW-1:0] CFG_EXT_HI = 1'd1;

    // Weight divider: 52 quotient bits, one per cycle
    localparam int unsigned DIV_STEPS = 52;
    localparam int unsigned DIV_CW    = 6;

    // One stored polar point, Re in the lowest bits
    typedef struct packed {
        logic signed [VAL_W-1:0] drag;
        logic signed [VAL_W-1:0] lift;
        logic signed [VAL_W-1:0] angle;
        logic        [VAL_W-1:0] re;
    } t_point;

    localparam int unsigned PT_W = $bits(t_point);

    typedef enum logic [34:0] {
        S_IDLE  = 35'd1 << 0,
        S_DONE  = 35'd1 << 1,
        S_QINIT = 35'd1 << 2,
        S_QLOW  = 35'd1 << 3,
        S_QHIGH = 35'd1 << 4,
        S_QBS   = 35'd1 << 5,
        S_QBSC  = 35'd1 << 6,
        S_QW0   = 35'd1 << 7,
        S_QW1   = 35'd1 << 8,
        S_QW2   = 35'd1 << 9,
        S_QW3   = 35'd1 << 10,
        S_QEV0  = 35'd1 << 11,
        S_QEV1  = 35'd1 << 12,
        S_QFL   = 35'd1 << 13,
        S_QFD   = 35'd1 << 14,
        S_GR0   = 35'd1 << 15,
        S_GR1   = 35'd1 << 16,
        S_GR2   = 35'd1 << 17,
        S_E0    = 35'd1 << 18,
        S_E1    = 35'd1 << 19,
        S_E2    = 35'd1 << 20,
        S_E3    = 35'd1 << 21,
        S_E4    = 35'd1 << 22,
        S_EBS   = 35'd1 << 23,
        S_EBSC  = 35'd1 << 24,
        S_EP0   = 35'd1 << 25,
        S_EP1   = 35'd1 << 26,
        S_EM0   = 35'd1 << 27,
        S_EM1   = 35'd1 << 28,
        S_EM2   = 35'd1 << 29,
        S_DINIT = 35'd1 << 30,
        S_DRUN  = 35'd1 << 31,
        S_DFIN  = 35'd1 << 32,
        S_M0    = 35'd1 << 33,
        S_M1    = 35'd1 << 34
    } t_state;

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sh0000_0000_7FFF_FFFF;
        lo = -64'sh0000_0000_8000_0000;
        if (v > hi) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = v[VAL_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

>>> hdl/apt_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none

module apt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [AW-1:0]            i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [AW-1:0]            i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> hdl/airfoil_polar_table_interpolator.sv
// Top level: polar point table with Re-group search and bilinear interpolation.
//
//  channel  | dir | handshake              | payload (lowest bit up)
//  ---------+-----+------------------------+------------------------------------------
//  s_axis   | in  | s_axis_tvalid/tready   | tuser: cmd; tdata: re, angle, lift, drag
//  m_axis   | out | m_axis_tvalid/tready   | tuser: status; tdata: lift_out, drag_out
//  cfg      | in  | i_cfg_we               | i_cfg_idx, i_cfg_wdata
//
// Clear, append and no-op go straight from idle to the done state; a query first
// runs the Re-group search and the angle interpolation. Each weight goes through
// the shared bit-serial divider; Re groups and angle rows are found by binary
// search, two RAM reads per group probe, one per row probe.
// Reset clears the counters and the extrapolation flags; the RAMs are not swept.
// A new transaction is taken in idle even while a result waits on m_axis; the
// next result is held back until the output register is free.
`default_nettype none

module airfoil_polar_table_interpolator
    import apt_pkg::*;
#(
    parameter int unsigned MAX_POINTS = 1024,
    parameter int unsigned MAX_GROUPS = 128
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    input  wire  [127:0]         s_axis_tdata,   // re, angle_in, lift_in, drag_in
    input  wire  [CMD_W-1:0]     s_axis_tuser,   // cmd
    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    output logic [63:0]          m_axis_tdata,   // lift_out, drag_out
    output logic [STAT_W-1:0]    m_axis_tuser,   // status
    input  wire                  i_cfg_we,
    input  wire  [CFG_IW-1:0]    i_cfg_idx,
    input  wire                  i_cfg_wdata
);
    localparam int unsigned PAW = $clog2(MAX_POINTS);
    localparam int unsigned PCW = $clog2(MAX_POINTS + 1);
    localparam int unsigned GAW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int unsigned GCW = $clog2(MAX_GROUPS + 1);

    t_state r_state, r_ret_gr, r_ret_ev, r_ret_div, r_ret_mul;

    // control
    logic           r_ovalid;
    logic [PCW-1:0] r_pcnt;
    logic [GCW-1:0] r_gcnt;
    logic           r_ext_lo, r_ext_hi;

    // payload
    logic [VAL_W-1:0]        r_last_re;
    logic signed [VAL_W-1:0] r_last_ang;
    logic [VAL_W-1:0]        r_re;
    logic signed [VAL_W-1:0] r_ang;
    logic [GCW-1:0]          r_g, r_glo, r_ghi, r_i0, r_i1;
    logic                    r_glast;
    logic [VAL_W-1:0]        r_gre, r_re0;
    logic [PCW-1:0]          r_s, r_e, r_plo, r_phi, r_pmid;
    t_point                  r_p0;
    logic signed [VAL_W-1:0] r_gl, r_gd, r_l0, r_d0, r_d1, r_wre;
    logic signed [VAL_W-1:0] r_res_l, r_res_d;
    logic [STAT_W-1:0]       r_res_st;
    logic signed [VAL_W-1:0] r_olift, r_odrag;
    logic [STAT_W-1:0]       r_ostat;

    // divider
    logic signed [32:0]      r_dx, r_dx0, r_dx1;
    logic                    r_dneg;
    logic [DIV_STEPS-1:0]    r_dsh;
    logic [34:0]             r_drem, r_dd;
    logic [DIV_CW-1:0]       r_dcnt;
    logic signed [VAL_W-1:0] r_dq;

    // multiplier
    logic signed [VAL_W-1:0] r_mf0, r_mf1, r_mw, r_mres;
    logic signed [64:0]      r_prod;

    // RAM ports
    t_point         in_pt, pt_q;
    logic [PT_W-1:0] pt_rdata;
    logic [PAW-1:0] pt_raddr;
    logic [GAW-1:0] gs_raddr;
    logic [PAW-1:0] gs_q;
    logic           pt_we, gs_we, in_acc;

    // append checks
    logic              a_fresh;
    logic [STAT_W-1:0] a_st;

    // helpers
    logic [GCW:0]       g_sum;
    logic [GCW-1:0]     g_mid, g_nxt, g_last;
    logic [PCW:0]       p_sum;
    logic [PCW-1:0]     p_mid, e_m1, plo_m1;
    logic signed [33:0] d_diff, d_den;
    logic signed [51:0] d_num;
    logic [51:0]        d_mag;
    logic [35:0]        d_trial;
    logic               d_ge;
    logic signed [52:0] d_qs, d_qf;
    logic signed [32:0] m_diff;
    logic signed [65:0] m_rnd;
    logic signed [49:0] m_t;
    logic signed [50:0] m_sum;

    assign in_pt  = t_point'(s_axis_tdata);
    assign pt_q   = t_point'(pt_rdata);
    assign in_acc = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_odrag, r_olift};
    assign m_axis_tuser  = r_ostat;

    // Append checks against the last stored point
    always_comb begin
        a_fresh = 1'b1;
        a_st    = ST_OK;
        if (r_pcnt >= PCW'(MAX_POINTS)) begin
            a_st = ST_FULL;
        end else if (r_pcnt != '0) begin
            if (in_pt.re < r_last_re) begin
                a_st = ST_ORDER;
            end else if (in_pt.re == r_last_re) begin
                a_fresh = 1'b0;
                if (in_pt.angle <= r_last_ang) a_st = ST_ORDER;
            end else if (r_gcnt >= GCW'(MAX_GROUPS)) begin
                a_st = ST_FULL;
            end
        end
    end

    assign pt_we = in_acc && (s_axis_tuser == CMD_APPEND) && (a_st == ST_OK);
    assign gs_we = pt_we && a_fresh;

    always_comb begin
        g_sum   = {1'b0, r_glo} + {1'b0, r_ghi};
        g_mid   = g_sum[GCW:1];
        g_nxt   = r_g + GCW'(1);
        g_last  = r_gcnt - GCW'(1);
        p_sum   = {1'b0, r_plo} + {1'b0, r_phi};
        p_mid   = p_sum[PCW:1];
        e_m1    = r_e - PCW'(1);
        plo_m1  = r_plo - PCW'(1);
        // weight = floor((2*(x-x0)*65536 + den) / (2*den))
        d_diff  = 34'(r_dx) - 34'(r_dx0);
        d_den   = 34'(r_dx1) - 34'(r_dx0);
        d_num   = (52'(d_diff) <<< 17) + 52'(d_den);
        d_mag   = d_num[51] ? 52'(-d_num) : 52'(d_num);
        d_trial = {r_drem, r_dsh[DIV_STEPS-1]};
        d_ge    = d_trial >= {1'b0, r_dd};
        d_qs    = {1'b0, r_dsh};
        if (!r_dneg)            d_qf = d_qs;
        else if (r_drem != '0)  d_qf = ~d_qs;
        else                    d_qf = -d_qs;
        // blend = f0 + floor(((f1-f0)*w + 32768) / 65536)
        m_diff  = 33'(r_mf1) - 33'(r_mf0);
        m_rnd   = 66'(r_prod) + 66'sd32768;
        m_t     = m_rnd[65:16];
        m_sum   = 51'(r_mf0) + 51'(m_t);
    end

    // RAM read addresses; data is used in the following state
    always_comb begin
        pt_raddr = '0;
        gs_raddr = '0;
        unique case (r_state)
            S_GR0:   gs_raddr = r_g[GAW-1:0];
            S_GR1:   pt_raddr = gs_q;
            S_E0:    gs_raddr = r_g[GAW-1:0];
            S_E1:    gs_raddr = g_nxt[GAW-1:0];
            S_E2:    pt_raddr = r_s[PAW-1:0];
            S_E3:    pt_raddr = e_m1[PAW-1:0];
            S_EBS:   pt_raddr = (r_plo < r_phi) ? p_mid[PAW-1:0] : plo_m1[PAW-1:0];
            S_EP0:   pt_raddr = r_plo[PAW-1:0];
            default: pt_raddr = '0;
        endcase
    end

    apt_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_point_ram (
        .i_clk   (i_clk),
        .i_we    (pt_we),
        .i_waddr (r_pcnt[PAW-1:0]),
        .i_wdata (s_axis_tdata),
        .i_raddr (pt_raddr),
        .o_rdata (pt_rdata)
    );

    // first point index of each Re group; the end of the last group is r_pcnt
    apt_ram #(.WIDTH(PAW), .DEPTH(MAX_GROUPS)) u_group_ram (
        .i_clk   (i_clk),
        .i_we    (gs_we),
        .i_waddr (r_gcnt[GAW-1:0]),
        .i_wdata (r_pcnt[PAW-1:0]),
        .i_raddr (gs_raddr),
        .o_rdata (gs_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_pcnt   <= '0;
            r_gcnt   <= '0;
            r_ext_lo <= 1'b0;
            r_ext_hi <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_EXT_LO: r_ext_lo <= i_cfg_wdata;
                    CFG_EXT_HI: r_ext_hi <= i_cfg_wdata;
                    default:    ;
                endcase
            end
            // output register: loaded from S_DONE, emptied by the sink
            if ((r_state == S_DONE) && (!r_ovalid || m_axis_tready)) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_re     <= in_pt.re;
                        r_ang    <= in_pt.angle;
                        r_res_l  <= '0;
                        r_res_d  <= '0;
                        r_res_st <= ST_OK;
                        r_state  <= S_DONE;
                        unique case (s_axis_tuser)
                            CMD_CLEAR: begin
                                r_pcnt <= '0;
                                r_gcnt <= '0;
                            end
                            CMD_APPEND: begin
                                r_res_st <= a_st;
                                if (a_st == ST_OK) begin
                                    r_pcnt     <= r_pcnt + PCW'(1);
                                    r_last_re  <= in_pt.re;
                                    r_last_ang <= in_pt.angle;
                                    if (a_fresh) r_gcnt <= r_gcnt + GCW'(1);
                                end
                            end
                            CMD_QUERY: begin
                                if (r_gcnt == '0) r_res_st <= ST_EMPTY;
                                else              r_state  <= S_QINIT;
                            end
                            default: ;
                        endcase
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_olift  <= r_res_l;
                        r_odrag  <= r_res_d;
                        r_ostat  <= r_res_st;
                        r_state  <= S_IDLE;
                    end
                end

                // ---- bracketing Re groups
                S_QINIT: begin
                    r_g <= '0;
                    if (r_gcnt == GCW'(1)) begin
                        r_i0     <= '0;
                        r_i1     <= '0;
                        r_ret_ev <= S_QEV0;
                        r_state  <= S_E0;
                    end else begin
                        r_ret_gr <= S_QLOW;
                        r_state  <= S_GR0;
                    end
                end
                S_QLOW: begin
                    if (r_re < r_gre) begin
                        r_i0 <= '0;
                        r_g  <= '0;
                        if (r_ext_lo) begin
                            r_i1    <= GCW'(1);
                            r_state <= S_QW0;
                        end else begin
                            r_i1     <= '0;
                            r_ret_ev <= S_QEV0;
                            r_state  <= S_E0;
                        end
                    end else begin
                        r_g      <= g_last;
                        r_ret_gr <= S_QHIGH;
                        r_state  <= S_GR0;
                    end
                end
                S_QHIGH: begin
                    if (r_re > r_gre) begin
                        r_i1 <= g_last;
                        if (r_ext_hi) begin
                            r_i0    <= g_last - GCW'(1);
                            r_state <= S_QW0;
                        end else begin
                            r_i0     <= g_last;
                            r_g      <= g_last;
                            r_ret_ev <= S_QEV0;
                            r_state  <= S_E0;
                        end
                    end else begin
                        r_glo   <= GCW'(1);
                        r_ghi   <= g_last;
                        r_state <= S_QBS;
                    end
                end
                S_QBS: begin
                    if (r_glo < r_ghi) begin
                        r_g      <= g_mid;
                        r_ret_gr <= S_QBSC;
                        r_state  <= S_GR0;
                    end else begin
                        r_i1    <= r_glo;
                        r_i0    <= r_glo - GCW'(1);
                        r_state <= S_QW0;
                    end
                end
                S_QBSC: begin
                    if (r_re <= r_gre) r_ghi <= r_g;
                    else               r_glo <= r_g + GCW'(1);
                    r_state <= S_QBS;
                end

                // ---- Re weight
                S_QW0: begin
                    r_g      <= r_i0;
                    r_ret_gr <= S_QW1;
                    r_state  <= S_GR0;
                end
                S_QW1: begin
                    r_re0    <= r_gre;
                    r_g      <= r_i1;
                    r_ret_gr <= S_QW2;
                    r_state  <= S_GR0;
                end
                S_QW2: begin
                    r_dx      <= 33'({1'b0, r_re});
                    r_dx0     <= 33'({1'b0, r_re0});
                    r_dx1     <= 33'({1'b0, r_gre});
                    r_ret_div <= S_QW3;
                    r_state   <= S_DINIT;
                end
                S_QW3: begin
                    r_wre    <= r_dq;
                    r_g      <= r_i0;
                    r_ret_ev <= S_QEV0;
                    r_state  <= S_E0;
                end

                // ---- group results and final blend
                S_QEV0: begin
                    r_l0 <= r_gl;
                    r_d0 <= r_gd;
                    if (r_i0 == r_i1) begin
                        r_res_l <= r_gl;
                        r_res_d <= r_gd;
                        r_state <= S_DONE;
                    end else begin
                        r_g      <= r_i1;
                        r_ret_ev <= S_QEV1;
                        r_state  <= S_E0;
                    end
                end
                S_QEV1: begin
                    r_d1      <= r_gd;
                    r_mf0     <= r_l0;
                    r_mf1     <= r_gl;
                    r_mw      <= r_wre;
                    r_ret_mul <= S_QFL;
                    r_state   <= S_M0;
                end
                S_QFL: begin
                    r_res_l   <= r_mres;
                    r_mf0     <= r_d0;
                    r_mf1     <= r_d1;
                    r_ret_mul <= S_QFD;
                    r_state   <= S_M0;
                end
                S_QFD: begin
                    r_res_d <= r_mres;
                    r_state <= S_DONE;
                end

                // ---- Re of group r_g: start index, then its first point
                S_GR0: r_state <= S_GR1;
                S_GR1: r_state <= S_GR2;
                S_GR2: begin
                    r_gre   <= pt_q.re;
                    r_state <= r_ret_gr;
                end

                // ---- angle interpolation inside group r_g
                S_E0: begin
                    r_glast <= (g_nxt == r_gcnt);
                    r_state <= S_E1;
                end
                S_E1: begin
                    r_s     <= PCW'(gs_q);
                    r_state <= S_E2;
                end
                S_E2: begin
                    r_e     <= r_glast ? r_pcnt : PCW'(gs_q);
                    r_state <= S_E3;
                end
                S_E3: begin
                    if (r_ang <= pt_q.angle) begin
                        r_gl    <= pt_q.lift;
                        r_gd    <= pt_q.drag;
                        r_state <= r_ret_ev;
                    end else begin
                        r_state <= S_E4;
                    end
                end
                S_E4: begin
                    if (r_ang >= pt_q.angle) begin
                        r_gl    <= pt_q.lift;
                        r_gd    <= pt_q.drag;
                        r_state <= r_ret_ev;
                    end else begin
                        r_plo   <= r_s + PCW'(1);
                        r_phi   <= e_m1;
                        r_state <= S_EBS;
                    end
                end
                S_EBS: begin
                    if (r_plo < r_phi) begin
                        r_pmid  <= p_mid;
                        r_state <= S_EBSC;
                    end else begin
                        r_state <= S_EP0;
                    end
                end
                S_EBSC: begin
                    if (r_ang <= pt_q.angle) r_phi <= r_pmid;
                    else                     r_plo <= r_pmid + PCW'(1);
                    r_state <= S_EBS;
                end
                S_EP0: begin
                    r_p0    <= pt_q;
                    r_state <= S_EP1;
                end
                S_EP1: begin
                    r_mf1     <= pt_q.lift;
                    r_d1      <= pt_q.drag;
                    r_dx      <= 33'(r_ang);
                    r_dx0     <= 33'(r_p0.angle);
                    r_dx1     <= 33'(pt_q.angle);
                    r_ret_div <= S_EM0;
                    r_state   <= S_DINIT;
                end
                S_EM0: begin
                    r_mf0     <= r_p0.lift;
                    r_mw      <= r_dq;
                    r_ret_mul <= S_EM1;
                    r_state   <= S_M0;
                end
                S_EM1: begin
                    r_gl      <= r_mres;
                    r_mf0     <= r_p0.drag;
                    r_mf1     <= r_d1;
                    r_ret_mul <= S_EM2;
                    r_state   <= S_M0;
                end
                S_EM2: begin
                    r_gd    <= r_mres;
                    r_state <= r_ret_ev;
                end

                // ---- shared restoring divider, one quotient bit a cycle
                S_DINIT: begin
                    r_dneg  <= d_num[51];
                    r_dsh   <= d_mag;
                    r_dd    <= {d_den[33:0], 1'b0};
                    r_drem  <= '0;
                    r_dcnt  <= '0;
                    r_state <= S_DRUN;
                end
                S_DRUN: begin
                    r_drem <= d_ge ? 35'(d_trial - {1'b0, r_dd}) : d_trial[34:0];
                    r_dsh  <= {r_dsh[DIV_STEPS-2:0], d_ge};
                    r_dcnt <= r_dcnt + DIV_CW'(1);
                    if (r_dcnt == DIV_CW'(DIV_STEPS - 1)) r_state <= S_DFIN;
                end
                S_DFIN: begin
                    r_dq    <= sat32(64'(d_qf));
                    r_state <= r_ret_div;
                end

                // ---- shared blend multiplier
                S_M0: begin
                    r_prod  <= 65'(m_diff) * 65'(r_mw);
                    r_state <= S_M1;
                end
                S_M1: begin
                    r_mres  <= sat32(64'(m_sum));
                    r_state <= r_ret_mul;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// Testbench for the airfoil polar table interpolator: directed cases, random tables, queries and checks.
`timescale 1ns / 100ps

module tb_top;
    import apt_pkg::*;

    localparam int NPTS = 1024;
    localparam int NGRP = 128;
    localparam int WATCHDOG = 20000;

    // Expected result of one transaction
    typedef struct {
        logic signed [31:0] lift;
        logic signed [31:0] drag;
        logic [1:0]         status;
    } t_polar_result;

    // Predictor holding its own copy of the polar table plus the result queue
    class polar_scoreboard;
        logic [31:0]        pt_re[NPTS];
        longint             pt_ang[NPTS];
        longint             pt_lift[NPTS];
        longint             pt_drag[NPTS];
        int unsigned        grp_first[NGRP+1];
        int unsigned        n_grp;
        int unsigned        n_pts;
        bit                 ext_lo;
        bit                 ext_hi;
        t_polar_result      pending[$];
        int                 n_err;

        function new();
            n_grp = 0; n_pts = 0; ext_lo = 0; ext_hi = 0; n_err = 0;
            foreach (grp_first[k]) grp_first[k] = 0;
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint fdiv(longint n, longint d);
            longint q;
            q = n / d;
            if ((n % d) != 0 && n < 0) q--;
            return q;
        endfunction

        function longint frac_of(longint x, longint x0, longint x1);
            longint den;
            den = x1 - x0;
            if (den <= 0) return 0;
            return clamp32(fdiv(2 * (x - x0) * 65536 + den, 2 * den));
        endfunction

        function longint mix(longint f0, longint f1, longint w);
            return clamp32(f0 + fdiv((f1 - f0) * w + 32768, 65536));
        endfunction

        function longint grp_re(int unsigned g);
            return longint'(pt_re[grp_first[g % (NGRP+1)] % NPTS]);
        endfunction

        // Angle interpolation inside one Re group, end points held
        function void angle_interp(int unsigned g, longint a, output longint lf,
                                   output longint dg);
            int unsigned s, e, i;
            longint w;
            s = grp_first[g % (NGRP+1)];
            e = grp_first[(g+1) % (NGRP+1)];
            if (e > n_pts) e = n_pts;
            if (s >= e) begin lf = 0; dg = 0; return; end
            if (a <= pt_ang[s]) begin lf = pt_lift[s]; dg = pt_drag[s]; return; end
            if (a >= pt_ang[e-1]) begin
                lf = pt_lift[e-1]; dg = pt_drag[e-1]; return;
            end
            for (i = s + 1; i < e - 1 && a > pt_ang[i]; i++) ;
            w = frac_of(a, pt_ang[i-1], pt_ang[i]);
            lf = mix(pt_lift[i-1], pt_lift[i], w);
            dg = mix(pt_drag[i-1], pt_drag[i], w);
        endfunction

        function logic [1:0] add_point(logic [31:0] re, longint a, longint lf, longint dg);
            bit fresh;
            fresh = 1;
            if (n_pts >= NPTS) return ST_FULL;
            if (n_pts > 0) begin
                if (re < pt_re[n_pts-1]) return ST_ORDER;
                if (re == pt_re[n_pts-1]) begin
                    if (a <= pt_ang[n_pts-1]) return ST_ORDER;
                    fresh = 0;
                end else if (n_grp >= NGRP) return ST_FULL;
            end
            if (fresh) begin
                grp_first[n_grp] = n_pts;
                n_grp++;
            end
            pt_re[n_pts] = re; pt_ang[n_pts] = a;
            pt_lift[n_pts] = lf; pt_drag[n_pts] = dg;
            n_pts++;
            grp_first[n_grp] = n_pts;
            return ST_OK;
        endfunction

        function void lookup(logic [31:0] re, longint a, ref t_polar_result r);
            int unsigned i0, i1;
            longint w, x, l0, d0, l1, d1;
            i0 = 0; i1 = 0; w = 0; x = longint'(re);
            if (n_grp == 0 || n_pts == 0) begin r.status = ST_EMPTY; return; end
            if (n_grp > 1) begin
                if (x < grp_re(0)) begin
                    if (ext_lo) begin i0 = 0; i1 = 1; end
                end else if (x > grp_re(n_grp-1)) begin
                    i0 = n_grp - 1; i1 = n_grp - 1;
                    if (ext_hi) i0 = n_grp - 2;
                end else begin
                    for (i1 = 1; i1 < n_grp - 1 && x > grp_re(i1); i1++) ;
                    i0 = i1 - 1;
                end
                if (i0 != i1) w = frac_of(x, grp_re(i0), grp_re(i1));
            end
            angle_interp(i0, a, l0, d0);
            angle_interp(i1, a, l1, d1);
            r.lift = 32'(mix(l0, l1, w));
            r.drag = 32'(mix(d0, d1, w));
        endfunction

        // Note one accepted input transaction
        function void note_command(logic [1:0] cmd, logic [127:0] d);
            t_polar_result r;
            r.lift = 0; r.drag = 0; r.status = ST_OK;
            if (cmd == CMD_CLEAR) begin
                n_pts = 0; n_grp = 0; grp_first[0] = 0;
            end else if (cmd == CMD_APPEND) begin
                r.status = add_point(d[31:0], longint'($signed(d[63:32])),
                                     longint'($signed(d[95:64])),
                                     longint'($signed(d[127:96])));
            end else if (cmd == CMD_QUERY) begin
                lookup(d[31:0], longint'($signed(d[63:32])), r);
                if (r.status != ST_OK) begin r.lift = 0; r.drag = 0; end
            end
            pending.push_back(r);
        endfunction

        // Check one accepted output transaction
        function void check_result(logic [63:0] d, logic [1:0] st);
            t_polar_result e;
            if (pending.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected result %h st %0d", d, st);
                return;
            end
            e = pending.pop_front();
            if (d[31:0] !== e.lift || d[63:32] !== e.drag || st !== e.status) begin
                n_err++;
                if (n_err <= 10)
                    $display("mismatch: exp lift %h drag %h st %0d, got %h %h %0d",
                             e.lift, e.drag, e.status, d[31:0], d[63:32], st);
            end
        endfunction
    endclass

    logic           i_clk = 0;
    logic           i_rst_n = 0;
    logic           s_axis_tvalid = 0;
    logic           s_axis_tready;
    logic [127:0]   s_axis_tdata = '0;    // re, angle_in, lift_in, drag_in
    logic [1:0]     s_axis_tuser = '0;    // cmd
    logic           m_axis_tvalid;
    logic           m_axis_tready = 0;
    logic [63:0]    m_axis_tdata;         // lift_out, drag_out
    logic [1:0]     m_axis_tuser;         // status
    logic           i_cfg_we = 0;
    logic [0:0]     i_cfg_idx = '0;
    logic           i_cfg_wdata = 0;

    polar_scoreboard sb = new();
    int  send_idle_pct = 0;   // sender gap chance per cycle, in percent
    int  recv_stall_pct = 0;  // receiver stall chance per cycle, in percent
    int  quiet_cycles = 0;
    bit  timed_out = 0;

    // Last Re/angle appended by the stimulus, used to build sorted tables
    logic [31:0]        cur_re;
    logic signed [31:0] cur_ang;

    always #5 i_clk = ~i_clk;

    airfoil_polar_table_interpolator DUT (.*);

    // Output side: random stalls, sample at the rising edge
    always @(negedge i_clk)
        m_axis_tready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (i_rst_n)
            quiet_cycles <= quiet_cycles + 1;
    end

    // Watchdog: nothing moved on either channel for too long
    always @(posedge i_clk) begin
        if (quiet_cycles >= WATCHDOG && !timed_out) begin
            timed_out = 1;
            $display("** airfoil_polar_table_interpolator: FAILED **");
            $finish;
        end
    end

    // Drive one transaction and hold it until the block takes it
    task automatic push_cmd(logic [1:0] cmd, logic [31:0] re, logic [31:0] ang,
                            logic [31:0] lf, logic [31:0] dg);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        s_axis_tvalid <= 1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {dg, lf, ang, re};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_command(cmd, {dg, lf, ang, re});
        @(negedge i_clk);
        s_axis_tvalid <= 0;
    endtask

    task automatic write_reg(logic idx, logic val);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
        if (idx == CFG_EXT_LO) sb.ext_lo = val; else sb.ext_hi = val;
        @(negedge i_clk);
    endtask

    // Let every expected result drain, then allow for the longest query
    task automatic drain();
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rnd_val();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(32'h0002_0000) - 32'h0001_0000;
            2: return {$urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000};
            default: return $urandom_range(32'h0000_4000);
        endcase
    endfunction

    // Well-formed table: a few groups of rising angles, random lift/drag
    task automatic build_table(int groups, int rows);
        push_cmd(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
        cur_re = $urandom_range(5000);
        for (int g = 0; g < groups; g++) begin
            cur_re = cur_re + $urandom_range(1, 100000);
            cur_ang = -$signed(32'($urandom_range(32'h0020_0000)));
            for (int r = 0; r < rows; r++) begin
                cur_ang = cur_ang + $signed(32'($urandom_range(1, 32'h0004_0000)));
                push_cmd(CMD_APPEND, cur_re, cur_ang, rnd_val(), rnd_val());
                // occasional broken entry: repeat angle or step Re backwards
                if ($urandom_range(19) == 0)
                    push_cmd(CMD_APPEND, cur_re - $urandom_range(1), cur_ang,
                             $urandom, $urandom);
            end
        end
    endtask

    task automatic query_burst(int n);
        logic [31:0] q_re;
        for (int k = 0; k < n; k++) begin
            q_re = $urandom_range(1) ? $urandom_range(cur_re + 200000) : $urandom;
            if ($urandom_range(9) == 0) push_cmd(CMD_NOP, $urandom, $urandom, $urandom, $urandom);
            else push_cmd(CMD_QUERY, q_re, $urandom_range(1) ? $urandom
                          : 32'($urandom_range(32'h0060_0000)) - 32'h0030_0000,
                          $urandom, $urandom);
        end
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed: empty table, extreme values, order and single-group cases
        push_cmd(CMD_QUERY, 32'd100, 32'd0, 32'd0, 32'd0);
        push_cmd(CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_cmd(CMD_APPEND, 32'd1000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        push_cmd(CMD_APPEND, 32'd1000, 32'h8000_0000, 32'd5, 32'd5);
        push_cmd(CMD_APPEND, 32'd1000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        push_cmd(CMD_QUERY, 32'd0, 32'd0, 32'd0, 32'd0);
        push_cmd(CMD_QUERY, 32'hFFFF_FFFF, 32'h8000_0000, 32'd0, 32'd0);
        push_cmd(CMD_APPEND, 32'd999, 32'd0, 32'd0, 32'd0);
        push_cmd(CMD_APPEND, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0001_0000, 32'd0);
        push_cmd(CMD_APPEND, 32'hFFFF_FFFF, 32'h0002_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        push_cmd(CMD_QUERY, 32'h8000_0000, 32'h0001_8000, 32'd0, 32'd0);
        push_cmd(CMD_QUERY, 32'd1, 32'h7FFF_FFFF, 32'd0, 32'd0);
        drain();
        write_reg(CFG_EXT_LO, 1'b1);
        write_reg(CFG_EXT_HI, 1'b1);
        push_cmd(CMD_QUERY, 32'd0, 32'h0001_0000, 32'd0, 32'd0);
        push_cmd(CMD_QUERY, 32'd500, 32'h8000_0000, 32'd0, 32'd0);
        push_cmd(CMD_CLEAR, 32'd0, 32'd0, 32'd0, 32'd0);
        push_cmd(CMD_QUERY, 32'd500, 32'd0, 32'd0, 32'd0);

        // Fill to capacity: groups limit, then points limit
        drain();
        push_cmd(CMD_CLEAR, 32'd0, 32'd0, 32'd0, 32'd0);
        for (int g = 0; g <= NGRP; g++)
            push_cmd(CMD_APPEND, 32'(g * 10), 32'd0, $urandom, $urandom);
        for (int p = 0; p < NPTS - NGRP + 1; p++)
            push_cmd(CMD_APPEND, 32'((NGRP - 1) * 10), 32'(p + 1), $urandom, $urandom);
        query_burst(20);

        // Random phases, each idling pattern with both high-end extrapolation settings
        for (int ph = 0; ph < 8; ph++) begin
            drain();
            write_reg(CFG_EXT_LO, ph[0]);
            write_reg(CFG_EXT_HI, ph[1] ^ ph[2]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            for (int t = 0; t < 3; t++) begin
                build_table($urandom_range(1, 6), $urandom_range(1, 6));
                query_burst(12);
            end
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();
        if (sb.n_err == 0)
            $display("** airfoil_polar_table_interpolator: PASSED **");
        else
            $display("** airfoil_polar_table_interpolator: FAILED **");
        $finish;
    end
endmodule

>>> files.f
hdl/apt_pkg.sv
hdl/apt_ram.sv
hdl/airfoil_polar_table_interpolator.sv
bench/tb_top.sv
